// ===== design/asma_pkg.sv =====
`timescale 1ns / 1ps

package asma_pkg;

	localparam int SLOTS      = 4;
	localparam int WINDOW_MAX = 16;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int POS_W      = $clog2(WINDOW_MAX);
	localparam int ADDR_W     = SLOT_W + POS_W;
	localparam int DEPTH      = SLOTS * WINDOW_MAX;

	localparam int SAMPLE_W = 24;
	localparam int SUM_W    = 28;
	localparam int VREF_W   = 13;
	localparam int CNT_W    = 3;
	localparam int MUX_W    = 16;
	localparam int CODE_W   = 4;
	localparam int WIN_W    = 5;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 16;

	// Scaling: |raw| (24 bits) times vref*1000 (23 bits) gives a 47-bit product.
	localparam int VK_W   = 23;
	localparam int PROD_W = 47;
	localparam int DVS_W  = 23;
	localparam int QUO_W  = 28;
	localparam int STEP_W = 4;

	// First division keeps the top DVS_W product bits as the starting remainder.
	localparam int D1_LOW = PROD_W - DVS_W;
	localparam int D1_PAD = QUO_W - D1_LOW;

	localparam int DIV1_STEPS = D1_LOW / 2;
	localparam int DIV2_STEPS = QUO_W / 2;

	localparam logic [DVS_W-1:0] SCALE_DIV = 23'h7FFFFF;
	localparam logic [9:0]       MV_TO_UV  = 10'd1000;

	localparam logic [VREF_W-1:0] VREF_RESET  = 13'd5000;
	localparam logic [CNT_W-1:0]  COUNT_RESET = 3'd1;
	localparam logic [WIN_W-1:0]  WIN_RESET   = 5'd1;

	localparam logic [IDX_W-1:0] REG_VREF  = 3'd0;
	localparam logic [IDX_W-1:0] REG_COUNT = 3'd1;
	localparam logic [IDX_W-1:0] REG_MUX   = 3'd2;
	localparam logic [IDX_W-1:0] REG_WIN0  = 3'd3;

	typedef struct packed {
		logic              start;
		logic [DVS_W-1:0]  rem_init;
		logic [QUO_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	// One restoring step: returns {quotient bit, new remainder}.
	function automatic logic [DVS_W:0] div_step(input logic [DVS_W-1:0] rem,
			input logic b, input logic [DVS_W-1:0] dvs);
		logic [DVS_W:0] t;
		logic [DVS_W:0] d;
		t = {rem, b};
		d = {1'b0, dvs};
		if (t >= d) begin
			t = t - d;
			return {1'b1, t[DVS_W-1:0]};
		end
		return {1'b0, t[DVS_W-1:0]};
	endfunction

	function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] w);
		if (w == '0)
			return WIN_W'(1);
		if (w > WIN_W'(WINDOW_MAX))
			return WIN_W'(WINDOW_MAX);
		return w;
	endfunction

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		if (c == '0)
			return CNT_W'(1);
		if (c > CNT_W'(SLOTS))
			return CNT_W'(SLOTS);
		return c;
	endfunction

	// (slot + 1) mod count, with count between 1 and SLOTS.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot,
			input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		n = CNT_W'(slot) + CNT_W'(1);
		for (int i = 0; i < SLOTS; i++) begin
			if (n >= cnt)
				n = n - cnt;
		end
		return n[SLOT_W-1:0];
	endfunction

endpackage

// ===== design/asma_in_if.sv =====
`timescale 1ns / 1ps

interface asma_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [asma_pkg::SAMPLE_W-1:0]  raw_sample;

	modport source(output valid, output raw_sample, input ready);
	modport sink(input valid, input raw_sample, output ready);
endinterface

// ===== design/asma_out_if.sv =====
`timescale 1ns / 1ps

interface asma_out_if;
	logic                                  valid;
	logic                                  ready;
	logic        [asma_pkg::SLOT_W-1:0]    slot_done;
	logic signed [asma_pkg::SAMPLE_W-1:0]  sample_uv;
	logic signed [asma_pkg::SAMPLE_W-1:0]  average_uv;
	logic        [asma_pkg::CODE_W-1:0]    next_mux;
	logic                                  restart;

	modport source(output valid, output slot_done, output sample_uv, output average_uv,
		output next_mux, output restart, input ready);
	modport sink(input valid, input slot_done, input sample_uv, input average_uv,
		input next_mux, input restart, output ready);
endinterface

// ===== design/asma_ram.sv =====
`timescale 1ns / 1ps

module asma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/asma_div.sv =====
`timescale 1ns / 1ps

module asma_div (
	input  logic               clk,
	input  logic               arst_n,
	input  asma_pkg::div_req_t req,
	output asma_pkg::div_rsp_t rsp
);

	logic [asma_pkg::DVS_W-1:0]  rem_q;
	logic [asma_pkg::QUO_W-1:0]  shr_q;
	logic [asma_pkg::DVS_W-1:0]  dvs_q;
	logic [asma_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [asma_pkg::DVS_W:0]    s1;
	logic [asma_pkg::DVS_W:0]    s2;
	logic [asma_pkg::QUO_W-1:0]  shr_nx;

	// Two quotient bits per cycle; quotient bits enter at the bottom of the
	// dividend shift register as the dividend bits leave at the top.
	always_comb begin
		s1 = asma_pkg::div_step(rem_q, shr_q[asma_pkg::QUO_W-1], dvs_q);
		s2 = asma_pkg::div_step(s1[asma_pkg::DVS_W-1:0], shr_q[asma_pkg::QUO_W-2], dvs_q);
		shr_nx = {shr_q[asma_pkg::QUO_W-3:0], s1[asma_pkg::DVS_W], s2[asma_pkg::DVS_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - asma_pkg::STEP_W'(1);
				if (cnt_q == asma_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			shr_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= s2[asma_pkg::DVS_W-1:0];
			shr_q <= shr_nx;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = shr_q;

`ifndef SYNTHESIS
	a_no_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider running with zero steps left");
`endif

endmodule

// ===== design/adc_scan_moving_average.sv =====
`timescale 1ns / 1ps

// Multichannel moving average for a scanning 24-bit converter. Each sample beat is
// scaled to microvolts (raw * vref_mv * 1000 / 0x7FFFFF, truncated toward zero),
// written into the current slot's ring of up to 16 samples, and the slot's
// running sum is divided by its window length to give the average. The result
// beat also carries the slot used, the mux code of the next slot in the
// round-robin scan and a restart flag when more than one slot is active. A new
// sample is not accepted until the previous one has finished its sequence. The
// scaling and the average share one two-bit-per-cycle divider: 12 steps for the
// scaling and 14 for the average, each ending in a done strobe. Input ready is
// held low while a sample is in progress, and longer if the previous result
// still waits in the output register when the next one is finished. The result
// sits in an output register, so a new sample may be accepted while the previous
// result still waits. Writing a window size clears that slot's ring, sum and
// ring position at once; reset does the same for all slots, so no clearing pass
// is needed. Registers are to be written by the user only while the block is
// idle; the block itself does not enforce this.
module adc_scan_moving_average (
	input  logic                          clk,
	input  logic                          arst_n,
	asma_in_if.sink                       sample,
	asma_out_if.source                    result,
	input  logic                          wr_en,
	input  logic [asma_pkg::IDX_W-1:0]    wr_index,
	input  logic [asma_pkg::CFG_W-1:0]    wr_data
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCALE = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_D1    = 4'd3;
	localparam logic [3:0] ST_W1    = 4'd4;
	localparam logic [3:0] ST_UPD   = 4'd5;
	localparam logic [3:0] ST_D2    = 4'd6;
	localparam logic [3:0] ST_W2    = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0] state_q;

	logic [asma_pkg::VREF_W-1:0] vref_q;
	logic [asma_pkg::CNT_W-1:0]  count_q;
	logic [asma_pkg::MUX_W-1:0]  mux_q;
	logic [asma_pkg::WIN_W-1:0]  win_q [asma_pkg::SLOTS];

	logic [asma_pkg::POS_W-1:0]         pos_q   [asma_pkg::SLOTS];
	logic signed [asma_pkg::SUM_W-1:0]  sums_q  [asma_pkg::SLOTS];
	logic [asma_pkg::WINDOW_MAX-1:0]    valid_q [asma_pkg::SLOTS];
	logic [asma_pkg::SLOT_W-1:0]        ptr_q;

	logic [asma_pkg::SAMPLE_W-1:0]        mag_q;
	logic                                 neg_q;
	logic [asma_pkg::SLOT_W-1:0]          slot_q;
	logic [asma_pkg::POS_W-1:0]           wpos_q;
	logic                                 old_vld_q;
	logic signed [asma_pkg::SAMPLE_W-1:0] old_q;
	logic [asma_pkg::VK_W-1:0]            vk_q;
	logic [asma_pkg::PROD_W-1:0]          prod_q;
	logic signed [asma_pkg::SAMPLE_W-1:0] uv_q;
	logic                                 sneg_q;
	logic signed [asma_pkg::SAMPLE_W-1:0] avg_q;

	logic                                 ov_q;
	logic [asma_pkg::SLOT_W-1:0]          o_slot_q;
	logic signed [asma_pkg::SAMPLE_W-1:0] o_uv_q;
	logic signed [asma_pkg::SAMPLE_W-1:0] o_avg_q;
	logic [asma_pkg::CODE_W-1:0]          o_mux_q;
	logic                                 o_rst_q;

	asma_pkg::div_req_t div_req;
	asma_pkg::div_rsp_t div_rsp;

	logic                                 in_acc;
	logic [asma_pkg::POS_W-1:0]           cur_pos;
	logic [asma_pkg::WIN_W-1:0]           upd_win;
	logic [asma_pkg::POS_W:0]             pos_inc;
	logic signed [asma_pkg::SUM_W-1:0]    sum_new;
	logic signed [asma_pkg::SUM_W-1:0]    sum_cur;
	logic [asma_pkg::SUM_W-1:0]           sum_abs;
	logic [asma_pkg::CNT_W-1:0]           count_eff;
	logic [asma_pkg::SAMPLE_W-1:0]        quo_lo;
	logic [asma_pkg::SAMPLE_W-1:0]        ram_rdata;
	logic                                 out_free;

	assign in_acc    = sample.valid && sample.ready;
	assign cur_pos   = pos_q[ptr_q];
	assign upd_win   = asma_pkg::eff_win(win_q[slot_q]);
	assign pos_inc   = {1'b0, wpos_q} + (asma_pkg::POS_W+1)'(1);
	assign sum_cur   = sums_q[slot_q];
	assign sum_new   = sum_cur - asma_pkg::SUM_W'(old_q) + asma_pkg::SUM_W'(uv_q);
	assign sum_abs   = sum_cur[asma_pkg::SUM_W-1] ? asma_pkg::SUM_W'(-sum_cur)
		: asma_pkg::SUM_W'(sum_cur);
	assign count_eff = asma_pkg::eff_count(count_q);
	assign quo_lo    = div_rsp.quotient[asma_pkg::SAMPLE_W-1:0];
	assign out_free  = !ov_q || result.ready;

	asma_ram #(
		.WIDTH(asma_pkg::SAMPLE_W),
		.DEPTH(asma_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (state_q == ST_UPD),
		.waddr({slot_q, wpos_q}),
		.wdata(uv_q),
		.re   (in_acc),
		.raddr({ptr_q, cur_pos}),
		.rdata(ram_rdata)
	);

	always_comb begin
		div_req = '0;
		case (state_q)
			ST_D1: begin
				div_req.start    = 1'b1;
				div_req.rem_init = prod_q[asma_pkg::PROD_W-1 -: asma_pkg::DVS_W];
				div_req.dividend = {prod_q[asma_pkg::D1_LOW-1:0],
					asma_pkg::D1_PAD'(0)};
				div_req.divisor  = asma_pkg::SCALE_DIV;
				div_req.steps    = asma_pkg::STEP_W'(asma_pkg::DIV1_STEPS);
			end
			ST_D2: begin
				div_req.start    = 1'b1;
				div_req.rem_init = '0;
				div_req.dividend = sum_abs;
				div_req.divisor  = asma_pkg::DVS_W'(upd_win);
				div_req.steps    = asma_pkg::STEP_W'(asma_pkg::DIV2_STEPS);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	asma_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer, configuration and per-slot state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vref_q  <= asma_pkg::VREF_RESET;
			count_q <= asma_pkg::COUNT_RESET;
			mux_q   <= '0;
			ptr_q   <= '0;
			ov_q    <= 1'b0;
			for (int s = 0; s < asma_pkg::SLOTS; s++) begin
				win_q[s]   <= asma_pkg::WIN_RESET;
				pos_q[s]   <= '0;
				sums_q[s]  <= '0;
				valid_q[s] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc)
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_D1;
				end
				ST_D1: begin
					state_q <= ST_W1;
				end
				ST_W1: begin
					if (div_rsp.done)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					sums_q[slot_q] <= sum_new;
					valid_q[slot_q][wpos_q] <= 1'b1;
					pos_q[slot_q] <= (pos_inc == (asma_pkg::POS_W+1)'(upd_win)) ? '0
						: pos_inc[asma_pkg::POS_W-1:0];
					ptr_q   <= asma_pkg::next_slot(slot_q, count_eff);
					state_q <= ST_D2;
				end
				ST_D2: begin
					state_q <= ST_W2;
				end
				ST_W2: begin
					if (div_rsp.done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (wr_en) begin
				case (wr_index)
					asma_pkg::REG_VREF:  vref_q  <= wr_data[asma_pkg::VREF_W-1:0];
					asma_pkg::REG_COUNT: count_q <= wr_data[asma_pkg::CNT_W-1:0];
					asma_pkg::REG_MUX:   mux_q   <= wr_data[asma_pkg::MUX_W-1:0];
					default: begin
						for (int s = 0; s < asma_pkg::SLOTS; s++) begin
							if (wr_index == asma_pkg::IDX_W'(asma_pkg::REG_WIN0 + s)) begin
								win_q[s]   <= wr_data[asma_pkg::WIN_W-1:0];
								pos_q[s]   <= '0;
								sums_q[s]  <= '0;
								valid_q[s] <= '0;
							end
						end
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q     <= sample.raw_sample[asma_pkg::SAMPLE_W-1];
			mag_q     <= sample.raw_sample[asma_pkg::SAMPLE_W-1]
				? asma_pkg::SAMPLE_W'(-sample.raw_sample)
				: asma_pkg::SAMPLE_W'(sample.raw_sample);
			slot_q    <= ptr_q;
			wpos_q    <= cur_pos;
			old_vld_q <= valid_q[ptr_q][cur_pos];
		end
		if (state_q == ST_SCALE) begin
			// Entries never written since the last clear read as zero.
			old_q <= old_vld_q ? ram_rdata : '0;
			vk_q  <= asma_pkg::VK_W'(vref_q) * asma_pkg::VK_W'(asma_pkg::MV_TO_UV);
		end
		if (state_q == ST_MUL)
			prod_q <= asma_pkg::PROD_W'(mag_q) * asma_pkg::PROD_W'(vk_q);
		if (state_q == ST_W1 && div_rsp.done)
			uv_q <= neg_q ? -quo_lo : quo_lo;
		if (state_q == ST_D2)
			sneg_q <= sum_cur[asma_pkg::SUM_W-1];
		if (state_q == ST_W2 && div_rsp.done)
			avg_q <= sneg_q ? -quo_lo : quo_lo;
		if (state_q == ST_DONE && out_free) begin
			o_slot_q <= slot_q;
			o_uv_q   <= uv_q;
			o_avg_q  <= avg_q;
			o_mux_q  <= mux_q[asma_pkg::CODE_W*ptr_q +: asma_pkg::CODE_W];
			o_rst_q  <= (count_eff > asma_pkg::CNT_W'(1));
		end
	end

	assign sample.ready      = (state_q == ST_IDLE);
	assign result.valid      = ov_q;
	assign result.slot_done  = o_slot_q;
	assign result.sample_uv  = o_uv_q;
	assign result.average_uv = o_avg_q;
	assign result.next_mux   = o_mux_q;
	assign result.restart    = o_rst_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_SCALE)
		else $error("accepted beat did not start the sequencer");
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_W1 || state_q == ST_W2))
		else $error("divider finished outside a wait state");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_DONE)
		else $error("result beat raised outside the done state");
	a_pos_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |->
		({1'b0, cur_pos} < (asma_pkg::POS_W+1)'(asma_pkg::eff_win(win_q[ptr_q]))))
		else $error("ring position outside the window");
`endif

endmodule
